[src/stream_classifier_table_defines.svh]
// Assertion macros for the stream classifier table checker.
// Standalone header; no dependencies.
`ifndef STREAM_CLASSIFIER_TABLE_DEFINES_SVH
`define STREAM_CLASSIFIER_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SCLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scls assertion failed");

// next-cycle implication, disabled during reset
`define SCLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scls assertion failed");

// state right after a reset cycle
`define SCLS_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("scls reset assertion failed");

`endif

[src/scls_pkg.sv]
// Shared types and constants of the stream classifier table.
// No dependencies.
package scls_pkg;

    typedef enum logic [1:0] {
        K_LOOKUP = 2'd0,
        K_ADD    = 2'd1,
        K_FLUSH  = 2'd2,
        K_OFF    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_COUNT = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_STREAMS   = 3'd3,
        ST_SLOTS     = 3'd4
    } t_status;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STREAM_LIMIT = 1'b0,
        REG_SLOT_LIMIT   = 1'b1
    } t_reg_idx;

    localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 4'd8;
    localparam logic [7:0]            MAX_FRAMES  = 8'd4;
    localparam logic [3:0]            COUNTER_MAX = 4'hf;
    localparam logic [3:0]            SLOT_CAP    = 4'd8;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] dest_ip;
        logic [31:0] com_id;
        logic [31:0] trigger_ns;
        logic [7:0]  frame_count;
        logic        restart;
    } t_req;

    typedef struct packed {
        logic [2:0] stream_id;
        logic       drop;
        t_status    status;
        logic [2:0] slot;
    } t_rsp;

endpackage

[src/scls_chan_if.sv]
// Valid/ready channel carrying one payload per transfer.
// Payload type is set at instantiation (scls_pkg::t_req or t_rsp).
interface scls_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/scls_cell.sv]
// One table entry of the classifier chain: stores the entry, merges its
// match and victim info into the carry from its left neighbor.
module scls_cell #(
    parameter int  TABLE_ENTRIES = 8,
    parameter int  IDX           = 0,
    parameter type t_carry       = logic,
    parameter type t_upd         = logic
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_upd   i_upd,
    input  t_carry i_carry,
    output t_carry o_carry
);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
    localparam logic [IDX_W-1:0] AGE_TOP = IDX_W'(TABLE_ENTRIES - 1);

    logic             r_valid;
    logic [IDX_W-1:0] r_age;
    logic [63:0]      r_key;
    logic [31:0]      r_trigger;
    logic [2:0]       r_frames;
    logic [3:0]       r_stream;
    logic             w_match;
    t_carry           n_carry;
    t_carry           r_carry;

    always_comb begin
        n_carry = i_carry;
        w_match = r_valid && (r_key == i_upd.key);
        // newest match wins; earlier cell keeps a tie
        if (w_match && (!i_carry.hit || (r_age < i_carry.age))) begin
            n_carry.hit     = 1'b1;
            n_carry.age     = r_age;
            n_carry.stream  = r_stream;
            n_carry.frames  = r_frames;
            n_carry.trigger = r_trigger;
        end
        if (!r_valid && !i_carry.free_hit) begin
            n_carry.free_hit = 1'b1;
            n_carry.free_idx = MY_IDX;
        end
        if (r_age > i_carry.max_age) begin
            n_carry.max_age = r_age;
            n_carry.max_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else if (i_upd.flush) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else if (i_upd.insert) begin
            if (i_upd.victim == MY_IDX) begin
                r_valid <= 1'b1;
                r_age   <= '0;
            end else if (r_valid && (r_age < AGE_TOP)) begin
                r_age <= r_age + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.insert && (i_upd.victim == MY_IDX)) begin
            r_key     <= i_upd.key;
            r_trigger <= i_upd.trigger;
            r_frames  <= i_upd.frames;
            r_stream  <= i_upd.stream;
        end
    end

    assign o_carry = r_carry;

endmodule

[src/stream_classifier_table.sv]
// Stream classifier table: a chain of TABLE_ENTRIES entry cells.
// The result is registered after the match/victim carry has walked through
//   the cell chain, one cell per cycle; a new item is accepted only in the
//   idle state, so one item is handled at a time.
// Reset (sync, active low): table empty, both counters 0, limits 8.
// The result register lets the next item in while a result is still waiting.
module stream_classifier_table #(
    parameter int TABLE_ENTRIES = 8,
    parameter int STREAM_IDS    = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    scls_chan_if.sink                        i_req,
    scls_chan_if.source                      o_rsp,
    input  logic                             i_cfg_we,
    input  logic [scls_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [scls_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import scls_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(TABLE_ENTRIES - 1);

    // carry handed from cell to cell: best match so far plus victim search
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] age;
        logic [3:0]       stream;
        logic [2:0]       frames;
        logic [31:0]      trigger;
        logic             free_hit;
        logic [IDX_W-1:0] free_idx;
        logic [IDX_W-1:0] max_age;
        logic [IDX_W-1:0] max_idx;
    } t_carry;

    // broadcast to all cells: compare key plus write/flush command
    typedef struct packed {
        logic             flush;
        logic             insert;
        logic [IDX_W-1:0] victim;
        logic [63:0]      key;
        logic [31:0]      trigger;
        logic [2:0]       frames;
        logic [3:0]       stream;
    } t_upd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_cnt;
    t_req             r_req;
    t_rsp             r_out;
    logic             r_out_valid;
    logic [3:0]       r_stream_cnt;
    logic [3:0]       r_slot_cnt;
    logic [3:0]       r_stream_limit;
    logic [3:0]       r_slot_limit;

    logic             w_in_fire;
    logic             w_fire;
    t_carry           w_chain [TABLE_ENTRIES+1];
    t_carry           w_final;
    t_upd             w_upd;
    t_upd             w_upd_g;
    t_rsp             w_res;
    logic [3:0]       n_stream_cnt;
    logic [3:0]       n_slot_cnt;
    logic [3:0]       w_sc;
    logic [3:0]       w_slc;
    logic [3:0]       w_sid;
    logic [3:0]       w_slim;
    logic [3:0]       w_flim;

    assign w_in_fire = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    // finish only when the result register is free this cycle
    assign w_fire = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // ---------------- cell chain ----------------
    assign w_chain[0] = '0;
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        scls_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .IDX           (g),
            .t_carry       (t_carry),
            .t_upd         (t_upd)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_upd   (w_upd_g),
            .i_carry (w_chain[g]),
            .o_carry (w_chain[g+1])
        );
    end
    assign w_final = w_chain[TABLE_ENTRIES];

    // ---------------- decision ----------------
    always_comb begin
        w_slim = r_stream_limit;
        if ({3'b000, r_stream_limit} > 7'(STREAM_IDS)) begin
            w_slim = 4'(STREAM_IDS);
        end
        w_flim = (r_slot_limit > SLOT_CAP) ? SLOT_CAP : r_slot_limit;

        w_res          = '0;
        w_res.status   = ST_OK;
        n_stream_cnt   = r_stream_cnt;
        n_slot_cnt     = r_slot_cnt;
        w_sc           = r_stream_cnt;
        w_slc          = r_slot_cnt;
        w_sid          = '0;
        w_upd          = '0;
        w_upd.key      = {r_req.com_id, r_req.dest_ip};
        w_upd.trigger  = r_req.trigger_ns;
        w_upd.frames   = r_req.frame_count[2:0];
        // first empty entry, else the oldest one
        w_upd.victim   = w_final.free_hit ? w_final.free_idx : w_final.max_idx;

        case (r_req.kind)
            K_LOOKUP: begin
                // counter at zero means classification is off
                if (r_stream_cnt != 4'd0) begin
                    if (w_final.hit) begin
                        w_res.stream_id = w_final.stream[2:0];
                    end else begin
                        w_res.drop = 1'b1;
                    end
                end
            end
            K_ADD: begin
                if (r_req.frame_count > MAX_FRAMES) begin
                    w_res.status = ST_BAD_COUNT;
                end else begin
                    w_sc         = r_req.restart ? 4'd0 : r_stream_cnt;
                    w_slc        = r_req.restart ? 4'd0 : r_slot_cnt;
                    n_stream_cnt = w_sc;
                    n_slot_cnt   = w_slc;
                    if (w_final.hit && ({5'b00000, w_final.frames} == r_req.frame_count)
                            && (w_final.trigger == r_req.trigger_ns)) begin
                        w_res.status    = ST_EXISTS;
                        w_res.stream_id = w_final.stream[2:0];
                    end else begin
                        if (w_final.hit) begin
                            w_sid = w_final.stream;
                        end else begin
                            // new id is consumed even if the add fails
                            w_sid = w_sc;
                            if (w_sc < COUNTER_MAX) begin
                                n_stream_cnt = w_sc + 4'd1;
                            end
                        end
                        if (w_sid >= w_slim) begin
                            w_res.status = ST_STREAMS;
                        end else if (w_slc >= w_flim) begin
                            w_res.status = ST_SLOTS;
                        end else begin
                            w_res.slot      = w_slc[2:0];
                            w_res.stream_id = w_sid[2:0];
                            n_slot_cnt      = w_slc + 4'd1;
                            w_upd.insert    = 1'b1;
                            w_upd.stream    = w_sid;
                        end
                    end
                end
            end
            K_FLUSH: begin
                w_upd.flush = 1'b1;
            end
            K_OFF: begin
                n_stream_cnt = 4'd0;
            end
            default: begin
            end
        endcase

        w_upd_g        = w_upd;
        w_upd_g.insert = w_upd.insert && w_fire;
        w_upd_g.flush  = w_upd.flush && w_fire;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_stream_cnt <= 4'd0;
            r_slot_cnt   <= 4'd0;
        end else begin
            // a new result wins over the transfer of the old one
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_state <= S_WALK;
                        r_cnt   <= '0;
                    end
                end
                S_WALK: begin
                    // stay here until the carry has passed through every cell
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_DONE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_fire) begin
                        r_state      <= S_IDLE;
                        r_stream_cnt <= n_stream_cnt;
                        r_slot_cnt   <= n_slot_cnt;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (w_in_fire) begin
            r_req <= i_req.data;
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_limit <= LIMIT_RESET;
            r_slot_limit   <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STREAM_LIMIT: r_stream_limit <= i_cfg_data;
                REG_SLOT_LIMIT:   r_slot_limit   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

[src/scls_checker.sv]
// Port-level checks of the stream classifier table, bound to the top level.
// Uses scls_pkg and stream_classifier_table_defines.svh.
`include "stream_classifier_table_defines.svh"

module scls_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input scls_pkg::t_rsp i_out_data
);
    import scls_pkg::*;

    // a held result keeps its value
    `SCLS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_data))
    // one item at a time: busy right after a transfer
    `SCLS_ASSERT_NXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // a result never shows up the cycle after its input
    `SCLS_ASSERT_NXT(a_no_early_out, i_clk, i_rst_n, i_in_valid && i_in_ready,
        !$rose(i_out_valid))
    // reset leaves the block empty and ready
    `SCLS_ASSERT_RST(a_reset_state, i_clk, i_rst_n, !i_out_valid && i_in_ready)

endmodule

bind stream_classifier_table scls_checker u_scls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);
